### design/sbf_pkg.sv
// ----------------------------------------------------------------------------
// Store buffer package
// Shared types, operation codes and result codes for the store buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

  // Operation codes carried with each input beat.
  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_FORWARD = 3'd1;
  localparam logic [2:0] ACT_RETIRE  = 3'd2;
  localparam logic [2:0] ACT_FLUSH_Y = 3'd3;
  localparam logic [2:0] ACT_FLUSH_A = 3'd4;

  // Result codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_PARTIAL = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_BUFFULL = 3'd4;

  // Width of one stored entry: id, address, data and byte count.
  localparam int unsigned ENTRY_W = 64 + 64 + 64 + 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } sbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sbf_stat_t;

endpackage

`default_nettype wire

### design/sbf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/sbf_ctrl.sv
// ----------------------------------------------------------------------------
// Store buffer controller
// Sequences one operation: a scan over every entry, a pipeline drain, and a
// final commit that writes back state and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ctrl
  import sbf_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire sbf_stat_t stat,
  output sbf_cmd_t       cmd
);

  localparam int unsigned IW = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [IW-1:0] cnt;
  logic [IW-1:0] cnt_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (cnt == IW'(ENTRIES - 1)) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        // The drain lets the last read pass the compare and merge stages.
        if (cnt[0]) begin
          state_next = S_FINISH;
        end
        cnt_next = cnt + 1'b1;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // A commit is never issued over a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.out_busy)
    else $error("commit while result pending");

  // A new operation starts only after the previous one committed.
  a_load_after_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE && !cmd.issue)
    else $error("load outside idle");

  // The scan always runs into the drain.
  a_scan_to_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && cnt == IW'(ENTRIES - 1) |=> state == S_DRAIN)
    else $error("scan did not end in drain");

endmodule

`default_nettype wire

### design/sbf_dp.sv
// ----------------------------------------------------------------------------
// Store buffer datapath
// Entry storage, valid bits, allocation pointer, the compare and merge
// pipeline that works on one entry per cycle, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_dp
  import sbf_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sbf_cmd_t    cmd,
  output sbf_stat_t        stat,
  input  wire logic [2:0]  in_action,
  input  wire logic [63:0] in_id,
  input  wire logic [63:0] in_address,
  input  wire logic [63:0] in_value,
  input  wire logic [3:0]  in_size,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [2:0]       out_status,
  output logic [63:0]      out_load_value,
  output logic [63:0]      out_prim_id,
  output logic             out_found,
  output logic [4:0]       out_count
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  // Operation registers.
  logic [2:0]  op_action;
  logic [63:0] op_id;
  logic [63:0] op_addr;
  logic [63:0] op_value;
  logic [3:0]  op_size;
  logic        size_ok;

  // Buffer state.
  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]      ap;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;

  // Scan pipeline.
  logic [IW-1:0] rd_ptr;
  logic          s1_v;
  logic [IW-1:0] s1_idx;
  logic          s2_v;
  logic [IW-1:0] s2_idx;
  logic [63:0]   s2_id;
  logic [63:0]   s2_addr;
  logic [63:0]   s2_data;
  logic          s2_older;
  logic          s2_ovl;
  logic          s2_exact;
  logic [63:0]   s2_ob;
  logic [63:0]   s2_oe;

  // Accumulated scan results.
  logic [IW-1:0] fp;
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          found;
  logic [63:0]   prim;
  logic          hit;
  logic [63:0]   hit_data;
  logic [63:0]   merged;
  logic [7:0]    mask;

  // RAM ports.
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [63:0]        r_id;
  logic [63:0]        r_addr;
  logic [63:0]        r_data;
  logic [3:0]         r_bytes;

  sbf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign {r_bytes, r_data, r_addr, r_id} = ram_rdata;
  assign size_ok = (op_size != 4'd0) && (op_size <= 4'd8);
  assign stat.out_busy = m_tvalid && !m_tready;

  // First compare stage on the entry just read.
  logic        c_older;
  logic        c_ovl;
  logic        c_exact;
  logic [63:0] c_ob;
  logic [63:0] c_oe;
  always_comb begin
    logic [63:0] e1;
    logic [63:0] e2;
    logic [63:0] send;
    logic [63:0] lend;
    e1      = r_addr + {60'd0, r_bytes} - 64'd1;
    e2      = op_addr + {60'd0, op_size} - 64'd1;
    send    = r_addr + {60'd0, r_bytes};
    lend    = op_addr + {60'd0, op_size};
    c_older = r_id < op_id;
    c_ovl   = (r_addr <= e2) && (op_addr <= e1);
    c_exact = (r_addr == op_addr) && (r_bytes == op_size);
    c_ob    = (op_addr > r_addr) ? op_addr : r_addr;
    c_oe    = (lend < send) ? lend : send;
  end

  // Byte merge for a contributing store.
  logic [63:0] m_merged;
  logic [7:0]  m_mask;
  always_comb begin
    logic [63:0] b;
    logic [7:0]  soff;
    logic [7:0]  byte_val;
    m_merged = merged;
    m_mask   = mask;
    for (int k = 0; k < 8; k++) begin
      b        = op_addr + 64'(k);
      soff     = 8'(b - s2_addr);
      byte_val = (soff[7:3] == 5'd0) ? s2_data[{soff[2:0], 3'b000} +: 8] : 8'd0;
      if ((4'(k) < op_size) && (b >= s2_ob) && (b < s2_oe) && !mask[k]) begin
        m_merged[k*8 +: 8] = byte_val;
        m_mask[k]          = 1'b1;
      end
    end
  end

  // Commit decisions.
  logic          add_ok;
  logic          add_fresh;
  logic [IW-1:0] add_slot;
  logic [7:0]    cover_mask;
  logic          s2_live;
  always_comb begin
    add_fresh = !match_found && free_found;
    add_ok    = match_found || free_found;
    add_slot  = match_found ? match_idx : free_idx;
    cover_mask = 8'((9'd1 << op_size) - 9'd1);
    s2_live   = s2_v && valid[s2_idx];
    ram_we    = cmd.finish && (op_action == ACT_ADD) && add_ok;
    ram_waddr = add_slot;
    ram_wdata = {op_size, op_value, op_addr, op_id};
    count_next = count;
    if (s2_live && (((op_action == ACT_RETIRE) && (s2_id <= op_id)) ||
                    ((op_action == ACT_FLUSH_Y) && (s2_id > op_id)))) begin
      count_next = count - 1'b1;
    end else if (cmd.finish && (op_action == ACT_ADD) && add_fresh) begin
      count_next = count + 1'b1;
    end else if (cmd.finish && (op_action == ACT_FLUSH_A)) begin
      count_next = '0;
    end
  end

  // Control state: valid bits, pointer, count, pipeline tags, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      ap       <= '0;
      count    <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      s1_v  <= cmd.issue;
      s2_v  <= s1_v;
      if (s2_live && (((op_action == ACT_RETIRE) && (s2_id <= op_id)) ||
                      ((op_action == ACT_FLUSH_Y) && (s2_id > op_id)))) begin
        valid[s2_idx] <= 1'b0;
      end
      if (cmd.finish) begin
        if ((op_action == ACT_ADD) && add_ok) begin
          valid[add_slot] <= 1'b1;
          if (add_fresh) begin
            ap <= (free_idx == LAST) ? '0 : free_idx + 1'b1;
          end
        end else if (op_action == ACT_FLUSH_A) begin
          valid <= '0;
          ap    <= '0;
        end
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Operation latch, scan pointers, pipeline payload and accumulators.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_action   <= in_action;
      op_id       <= in_id;
      op_addr     <= in_address;
      op_value    <= in_value;
      op_size     <= in_size;
      rd_ptr      <= (in_action == ACT_FORWARD) ? ((ap == '0) ? LAST : ap - 1'b1) : '0;
      fp          <= ap;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      found       <= 1'b0;
      prim        <= '0;
      hit         <= 1'b0;
      hit_data    <= '0;
      merged      <= '0;
      mask        <= '0;
    end else begin
      if (cmd.issue) begin
        if (op_action == ACT_FORWARD) begin
          rd_ptr <= (rd_ptr == '0) ? LAST : rd_ptr - 1'b1;
        end else begin
          rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
        end
      end
      if (s2_v && (op_action == ACT_ADD)) begin
        // Lowest matching index wins; free slots are searched from the pointer.
        if (s2_live && (s2_id == op_id) && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= s2_idx;
        end
        if (!free_found && !valid[fp]) begin
          free_found <= 1'b1;
          free_idx   <= fp;
        end
        fp <= (fp == LAST) ? '0 : fp + 1'b1;
      end
      if (s2_live && (op_action == ACT_FORWARD) && size_ok && !hit &&
          s2_older && s2_ovl) begin
        if (!found) begin
          found <= 1'b1;
          prim  <= s2_id;
        end
        merged <= m_merged;
        mask   <= m_mask;
        if (s2_exact) begin
          hit      <= 1'b1;
          hit_data <= s2_data;
          prim     <= s2_id;
        end
      end
    end
    s1_idx   <= rd_ptr;
    s2_idx   <= s1_idx;
    s2_id    <= r_id;
    s2_addr  <= r_addr;
    s2_data  <= r_data;
    s2_older <= c_older;
    s2_ovl   <= c_ovl;
    s2_exact <= c_exact;
    s2_ob    <= c_ob;
    s2_oe    <= c_oe;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status     <= ST_OK;
      out_load_value <= '0;
      out_prim_id    <= '0;
      out_found      <= 1'b0;
      out_count      <= 5'(count_next);
      if ((op_action == ACT_ADD) && !add_ok) begin
        out_status <= ST_BUFFULL;
      end else if ((op_action == ACT_FORWARD) && found) begin
        out_found   <= 1'b1;
        out_prim_id <= prim;
        if (hit) begin
          out_status     <= ST_FULL;
          out_load_value <= hit_data;
        end else if (mask == cover_mask) begin
          out_status     <= ST_PARTIAL;
          out_load_value <= merged;
        end else begin
          out_status <= ST_BLOCKED;
        end
      end
    end
  end

  // The running count always equals the number of valid entries.
  a_count: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid)))
    else $error("occupied count out of step with valid bits");

  // The allocation pointer stays inside the buffer.
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    32'(ap) < ENTRIES)
    else $error("allocation pointer out of range");

  // Each operation starts with an empty compare pipeline.
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !s1_v && !s2_v)
    else $error("operation started with pipeline busy");

endmodule

`default_nettype wire

### design/store_buffer_load_forwarding.sv
// ----------------------------------------------------------------------------
// Store buffer with store-to-load forwarding
// A new operation is accepted only after the previous one has committed its
// result; the entry scan reads the single RAM read port once per cycle and
// passes two compare/merge stages. Reset clears valid bits, allocation
// pointer and count at once; the entry RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module store_buffer_load_forwarding
  import sbf_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // inst_id[63:0], address[127:64], store_value[191:128],
  // access_size[195:192], zero fill [199:196]
  input  wire logic [199:0] s_tdata,
  // action[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[2:0], load_value[66:3], primary_store_id[130:67],
  // primary_found[131], occupied_count[136:132], zero fill [143:137]
  output logic [143:0]      m_tdata
);

  sbf_cmd_t    cmd;
  sbf_stat_t   stat;
  logic [2:0]  out_status;
  logic [63:0] out_load_value;
  logic [63:0] out_prim_id;
  logic        out_found;
  logic [4:0]  out_count;

  sbf_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbf_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (s_tuser),
    .in_id          (s_tdata[63:0]),
    .in_address     (s_tdata[127:64]),
    .in_value       (s_tdata[191:128]),
    .in_size        (s_tdata[195:192]),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .out_status     (out_status),
    .out_load_value (out_load_value),
    .out_prim_id    (out_prim_id),
    .out_found      (out_found),
    .out_count      (out_count)
  );

  // Pack the result beat.
  assign m_tdata = {7'd0, out_count, out_found, out_prim_id, out_load_value, out_status};

endmodule

`default_nettype wire
